// File: hw/rtl/mlh_pkg.sv
// shared types and constants for the max line hull table
// state encodings, line entry layout and breakpoint limits; no dependencies
package mlh_pkg;

	localparam int MAX_LINES_DEF = 64;
	localparam int SLOPE_W       = 32;
	localparam int INTERCEPT_W   = 63;
	localparam int QUERY_W       = 32;
	localparam int VALUE_W       = 64;
	localparam int DIVISOR_W     = SLOPE_W + 1;

	localparam logic signed [VALUE_W-1:0] LIM_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VALUE_W-1:0] LIM_NEG = 64'sh8000_0000_0000_0001;

	typedef struct packed {
		logic [SLOPE_W-1:0]     slope;
		logic [INTERCEPT_W-1:0] intercept;
		logic [VALUE_W-1:0]     bp;
	} line_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_Q_RD,
		ST_Q_CMP,
		ST_Q_MUL,
		ST_Q_ADD,
		ST_INS_TOP,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_CUT_RDA,
		ST_CUT_RDB,
		ST_CUT_EVAL,
		ST_CUT_DEC,
		ST_CUT_DIV,
		ST_CUT_WR,
		ST_RM_RD,
		ST_RM_WR,
		ST_P3_STEP,
		ST_P3_RDB,
		ST_P3_CMP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RET_FIRST,
		RET_LEFT,
		RET_FIX
	} ret_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_PREP,
		DV_RUN,
		DV_DONE
	} div_state_t;

endpackage

// File: hw/rtl/mlh_if.sv
// command and result channels of the max line hull table
// valid/ready handshake with payload; uses mlh_pkg for field widths
interface mlh_cmd_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   func;
	logic signed [mlh_pkg::SLOPE_W-1:0]     slope;
	logic signed [mlh_pkg::INTERCEPT_W-1:0] intercept;
	logic signed [mlh_pkg::QUERY_W-1:0]     query_point;

	modport source(output valid, func, slope, intercept, query_point, input ready);
	modport sink(input valid, func, slope, intercept, query_point, output ready);
endinterface

interface mlh_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [mlh_pkg::VALUE_W-1:0] value;
	logic                               empty_res;
	logic                               dropped;

	modport source(output valid, value, empty_res, dropped, input ready);
	modport sink(input valid, value, empty_res, dropped, output ready);
endinterface

// File: hw/rtl/max_line_hull_table.sv
// top level of the max line hull table: sequencer, line memory and query multiply
// depends on mlh_pkg, mlh_if and mlh_floor_div

// The table keeps the upper envelope of up to MAX_LINES lines in one line memory
// (one read and one write port, registered read) and handles one item at a time.
// A query scans the lines from the low-slope end. An insert first moves each stored
// line of larger slope up, then updates breakpoints, with a division when an update
// needs one (the floored divider yields one quotient bit a cycle), and moves lines
// down when a pruned line is removed. A dropped insert or an empty query goes
// straight to the result. The result sits in an output register, so the next item
// is taken while a result still waits. No clearing pass follows reset.
module max_line_hull_table #(
	parameter int MAX_LINES = mlh_pkg::MAX_LINES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mlh_cmd_if.sink       cmd,
	mlh_res_if.source     res
);
	localparam int AW = $clog2(MAX_LINES);
	localparam int CW = $clog2(MAX_LINES + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_LINES);

	mlh_pkg::state_t state_q, state_d;
	mlh_pkg::ret_t   ret_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] a_q;
	logic [CW-1:0] y_q;
	logic [CW-1:0] xi_q;
	logic [CW-1:0] rm_q;

	logic [mlh_pkg::SLOPE_W-1:0]     k_q;
	logic [mlh_pkg::INTERCEPT_W-1:0] m_q;
	logic [mlh_pkg::QUERY_W-1:0]     x_q;
	mlh_pkg::line_t                  line_a_q;
	mlh_pkg::line_t                  line_b_q;
	logic signed [mlh_pkg::VALUE_W-1:0] bp_q;
	logic signed [mlh_pkg::VALUE_W-1:0] prod_q;
	logic [mlh_pkg::VALUE_W-1:0]     val_q;
	logic                            empty_q;
	logic                            drop_q;

	logic                        res_valid_q;
	logic [mlh_pkg::VALUE_W-1:0] res_value_q;
	logic                        res_empty_q;
	logic                        res_drop_q;

	mlh_pkg::line_t mem [MAX_LINES];
	mlh_pkg::line_t mem_rdata_q;
	mlh_pkg::line_t mem_wdata;
	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_waddr;
	logic [AW-1:0]  mem_raddr;

	logic                                 div_start;
	logic                                 div_done;
	logic signed [mlh_pkg::VALUE_W-1:0]   div_q;
	logic signed [mlh_pkg::VALUE_W-1:0]   div_a;
	logic signed [mlh_pkg::DIVISOR_W-1:0] div_b;

	logic [CW-1:0] idx_m1, a_p1, rm_p1, xi_m1, xi_p1, y_m1, y_p1;
	logic          q_more, ins_stop, b_last, slope_eq, m_gt, dom, rm_end, p3_ge, res_load;

	assign idx_m1 = idx_q - 1'b1;
	assign a_p1   = a_q + 1'b1;
	assign rm_p1  = rm_q + 1'b1;
	assign xi_m1  = xi_q - 1'b1;
	assign xi_p1  = xi_q + 1'b1;
	assign y_m1   = y_q - 1'b1;
	assign y_p1   = y_q + 1'b1;

	assign q_more   = (idx_q + 1'b1 < count_q)
		&& ($signed(mem_rdata_q.bp) < 64'($signed(x_q)));
	assign ins_stop = $signed(mem_rdata_q.slope) <= $signed(k_q);
	assign b_last   = a_p1 >= count_q;
	assign slope_eq = line_a_q.slope == line_b_q.slope;
	assign m_gt     = $signed(line_a_q.intercept) > $signed(line_b_q.intercept);
	assign dom      = !b_last && (bp_q >= $signed(line_b_q.bp));
	assign rm_end   = rm_p1 >= count_q;
	assign p3_ge    = $signed(line_a_q.bp) >= $signed(mem_rdata_q.bp);
	assign res_load = (state_q == mlh_pkg::ST_DONE) && (!res_valid_q || res.ready);

	assign div_a = 64'($signed(line_b_q.intercept)) - 64'($signed(line_a_q.intercept));
	assign div_b = 33'($signed(line_a_q.slope)) - 33'($signed(line_b_q.slope));

	mlh_floor_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re) mem_rdata_q <= mem[mem_raddr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mlh_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					if (cmd.func) begin
						state_d = (count_q == '0) ? mlh_pkg::ST_DONE : mlh_pkg::ST_Q_RD;
					end else begin
						state_d = (count_q == FULL) ? mlh_pkg::ST_DONE : mlh_pkg::ST_INS_TOP;
					end
				end
			end
			mlh_pkg::ST_Q_RD:  state_d = mlh_pkg::ST_Q_CMP;
			mlh_pkg::ST_Q_CMP: state_d = q_more ? mlh_pkg::ST_Q_RD : mlh_pkg::ST_Q_MUL;
			mlh_pkg::ST_Q_MUL: state_d = mlh_pkg::ST_Q_ADD;
			mlh_pkg::ST_Q_ADD: state_d = mlh_pkg::ST_DONE;
			mlh_pkg::ST_INS_TOP: begin
				state_d = (idx_q == '0) ? mlh_pkg::ST_INS_PUT : mlh_pkg::ST_INS_CMP;
			end
			mlh_pkg::ST_INS_CMP: begin
				state_d = ins_stop ? mlh_pkg::ST_INS_PUT : mlh_pkg::ST_INS_TOP;
			end
			mlh_pkg::ST_INS_PUT:  state_d = mlh_pkg::ST_CUT_RDA;
			mlh_pkg::ST_CUT_RDA:  state_d = mlh_pkg::ST_CUT_RDB;
			mlh_pkg::ST_CUT_RDB:  state_d = mlh_pkg::ST_CUT_EVAL;
			mlh_pkg::ST_CUT_EVAL: state_d = mlh_pkg::ST_CUT_DEC;
			mlh_pkg::ST_CUT_DEC: begin
				state_d = (b_last || slope_eq) ? mlh_pkg::ST_CUT_WR : mlh_pkg::ST_CUT_DIV;
			end
			mlh_pkg::ST_CUT_DIV: begin
				if (div_done) state_d = mlh_pkg::ST_CUT_WR;
			end
			mlh_pkg::ST_CUT_WR: begin
				case (ret_q)
					mlh_pkg::RET_FIRST: begin
						if (dom) state_d = mlh_pkg::ST_RM_RD;
						else if (y_q == '0) state_d = mlh_pkg::ST_DONE;
						else state_d = mlh_pkg::ST_CUT_RDA;
					end
					mlh_pkg::RET_LEFT: begin
						state_d = dom ? mlh_pkg::ST_RM_RD : mlh_pkg::ST_P3_STEP;
					end
					mlh_pkg::RET_FIX: state_d = mlh_pkg::ST_P3_STEP;
					default: state_d = mlh_pkg::ST_DONE;
				endcase
			end
			mlh_pkg::ST_RM_RD: state_d = rm_end ? mlh_pkg::ST_CUT_RDA : mlh_pkg::ST_RM_WR;
			mlh_pkg::ST_RM_WR: state_d = mlh_pkg::ST_RM_RD;
			mlh_pkg::ST_P3_STEP: begin
				state_d = (xi_q == '0) ? mlh_pkg::ST_DONE : mlh_pkg::ST_P3_RDB;
			end
			mlh_pkg::ST_P3_RDB: state_d = mlh_pkg::ST_P3_CMP;
			mlh_pkg::ST_P3_CMP: state_d = p3_ge ? mlh_pkg::ST_RM_RD : mlh_pkg::ST_DONE;
			mlh_pkg::ST_DONE: begin
				if (res_load) state_d = mlh_pkg::ST_IDLE;
			end
			default: state_d = mlh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = line_a_q;
		div_start = 1'b0;
		case (state_q)
			mlh_pkg::ST_Q_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q[AW-1:0];
			end
			mlh_pkg::ST_INS_TOP: begin
				mem_re    = idx_q != '0;
				mem_raddr = idx_m1[AW-1:0];
			end
			mlh_pkg::ST_INS_CMP: begin
				mem_we    = !ins_stop;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = mem_rdata_q;
			end
			mlh_pkg::ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = '{slope: k_q, intercept: m_q, bp: '0};
			end
			mlh_pkg::ST_CUT_RDA: begin
				mem_re    = 1'b1;
				mem_raddr = a_q[AW-1:0];
			end
			mlh_pkg::ST_CUT_RDB: begin
				mem_re    = !b_last;
				mem_raddr = a_p1[AW-1:0];
			end
			mlh_pkg::ST_CUT_DEC: begin
				div_start = !b_last && !slope_eq;
			end
			mlh_pkg::ST_CUT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = a_q[AW-1:0];
				mem_wdata = '{slope: line_a_q.slope, intercept: line_a_q.intercept, bp: bp_q};
			end
			mlh_pkg::ST_RM_RD: begin
				mem_re    = !rm_end;
				mem_raddr = rm_p1[AW-1:0];
			end
			mlh_pkg::ST_RM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = rm_q[AW-1:0];
				mem_wdata = mem_rdata_q;
			end
			mlh_pkg::ST_P3_STEP: begin
				mem_re    = xi_q != '0;
				mem_raddr = xi_m1[AW-1:0];
			end
			mlh_pkg::ST_P3_RDB: begin
				mem_re    = 1'b1;
				mem_raddr = xi_p1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign cmd.ready     = (state_q == mlh_pkg::ST_IDLE);
	assign res.valid     = res_valid_q;
	assign res.value     = res_value_q;
	assign res.empty_res = res_empty_q;
	assign res.dropped   = res_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mlh_pkg::ST_IDLE;
			ret_q       <= mlh_pkg::RET_FIRST;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mlh_pkg::ST_INS_PUT) begin
				count_q <= count_q + 1'b1;
				ret_q   <= mlh_pkg::RET_FIRST;
			end
			if (state_q == mlh_pkg::ST_RM_RD && rm_end) count_q <= count_q - 1'b1;
			if (state_q == mlh_pkg::ST_CUT_WR) begin
				if (ret_q == mlh_pkg::RET_FIRST && !dom) ret_q <= mlh_pkg::RET_LEFT;
				if (ret_q == mlh_pkg::RET_LEFT && dom) ret_q <= mlh_pkg::RET_FIX;
			end
			if (state_q == mlh_pkg::ST_P3_CMP && p3_ge) ret_q <= mlh_pkg::RET_FIX;
			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_value_q <= val_q;
			res_empty_q <= empty_q;
			res_drop_q  <= drop_q;
		end
		case (state_q)
			mlh_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					k_q     <= cmd.slope;
					m_q     <= cmd.intercept;
					x_q     <= cmd.query_point;
					val_q   <= '0;
					empty_q <= cmd.func && (count_q == '0);
					drop_q  <= !cmd.func && (count_q == FULL);
					idx_q   <= cmd.func ? '0 : count_q;
				end
			end
			mlh_pkg::ST_Q_CMP: begin
				if (q_more) idx_q <= idx_q + 1'b1;
				else line_a_q <= mem_rdata_q;
			end
			mlh_pkg::ST_Q_MUL: begin
				prod_q <= 64'($signed(line_a_q.slope) * $signed(x_q));
			end
			mlh_pkg::ST_Q_ADD: begin
				val_q <= prod_q + 64'($signed(line_a_q.intercept));
			end
			mlh_pkg::ST_INS_CMP: begin
				if (!ins_stop) idx_q <= idx_m1;
			end
			mlh_pkg::ST_INS_PUT: begin
				y_q <= idx_q;
				a_q <= idx_q;
			end
			mlh_pkg::ST_CUT_RDB:  line_a_q <= mem_rdata_q;
			mlh_pkg::ST_CUT_EVAL: line_b_q <= mem_rdata_q;
			mlh_pkg::ST_CUT_DEC: begin
				if (b_last) bp_q <= mlh_pkg::LIM_POS;
				else if (slope_eq) bp_q <= m_gt ? mlh_pkg::LIM_POS : mlh_pkg::LIM_NEG;
			end
			mlh_pkg::ST_CUT_DIV: begin
				if (div_done) bp_q <= div_q;
			end
			mlh_pkg::ST_CUT_WR: begin
				if (ret_q == mlh_pkg::RET_FIRST) begin
					if (dom) begin
						rm_q <= y_p1;
					end else begin
						a_q  <= y_m1;
						xi_q <= y_m1;
					end
				end else if (ret_q == mlh_pkg::RET_LEFT && dom) begin
					rm_q <= y_q;
				end
			end
			mlh_pkg::ST_RM_WR: rm_q <= rm_p1;
			mlh_pkg::ST_P3_STEP: begin
				if (xi_q != '0) xi_q <= xi_m1;
			end
			mlh_pkg::ST_P3_RDB: line_a_q <= mem_rdata_q;
			mlh_pkg::ST_P3_CMP: begin
				if (p3_ge) begin
					rm_q <= xi_p1;
					a_q  <= xi_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("line memory read and write of one entry in one cycle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1)))
		else $error("line count moved by more than one");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("line count beyond table size");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_drop_q) |-> (count_q == FULL))
		else $error("insert dropped while table not full");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_empty_q) |-> (res_value_q == '0) && !res_drop_q)
		else $error("empty query transfer with nonzero value");
`endif

endmodule

// File: hw/rtl/mlh_floor_div.sv
// multicycle floored signed division, one quotient bit per cycle
// 64-bit dividend by 33-bit nonzero divisor; uses mlh_pkg
module mlh_floor_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [mlh_pkg::VALUE_W-1:0]   dividend,
	input  logic signed [mlh_pkg::DIVISOR_W-1:0] divisor,
	output logic                                 done,
	output logic signed [mlh_pkg::VALUE_W-1:0]   quotient
);
	localparam int NW = mlh_pkg::VALUE_W;
	localparam int DW = mlh_pkg::DIVISOR_W;
	localparam int CNTW = $clog2(NW);

	mlh_pkg::div_state_t state_q, state_d;

	logic [NW-1:0]   num_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;
	logic            neg_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW:0]     shifted;
	logic [DW:0]     diff;
	logic            ge;

	assign shifted = {rem_q, num_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			mlh_pkg::DV_IDLE: begin
				if (start) state_d = mlh_pkg::DV_PREP;
			end
			mlh_pkg::DV_PREP: state_d = mlh_pkg::DV_RUN;
			mlh_pkg::DV_RUN: begin
				if (cnt_q == '0) state_d = mlh_pkg::DV_DONE;
			end
			mlh_pkg::DV_DONE: state_d = mlh_pkg::DV_IDLE;
			default: state_d = mlh_pkg::DV_IDLE;
		endcase
	end

	// floor correction: negative results with a remainder step down by one
	always_comb begin
		done     = (state_q == mlh_pkg::DV_DONE);
		quotient = neg_q ? $signed(~num_q + {{(NW-1){1'b0}}, rem_q == '0}) : $signed(num_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlh_pkg::DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mlh_pkg::DV_IDLE: begin
				if (start) begin
					num_q <= dividend;
					den_q <= divisor;
					neg_q <= dividend[NW-1] ^ divisor[DW-1];
					rem_q <= '0;
					cnt_q <= CNTW'(NW - 1);
				end
			end
			mlh_pkg::DV_PREP: begin
				if (num_q[NW-1]) num_q <= ~num_q + 1'b1;
				if (den_q[DW-1]) den_q <= ~den_q + 1'b1;
			end
			mlh_pkg::DV_RUN: begin
				rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
				num_q <= {num_q[NW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: tb/testbench.sv
// testbench for max_line_hull_table: random and directed inserts and queries,
// checked against a line-envelope predictor; uses mlh_pkg, mlh_if and the rtl top
`timescale 1ns / 100ps

module testbench;

	localparam int TBL_DEPTH = mlh_pkg::MAX_LINES_DEF;
	localparam bit FN_INSERT = 1'b0;
	localparam bit FN_QUERY  = 1'b1;

	typedef struct {
		bit          func;
		longint      slope;
		longint      intercept;
		longint      qx;
	} hull_cmd_t;

	typedef struct {
		longint value;
		bit     empty_res;
		bit     dropped;
	} hull_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   started = 1'b0;
	bit   hold = 1'b0;
	bit   cmd_taken = 1'b0;
	bit   res_taken = 1'b0;
	int   cmd_gap = 0;
	int   res_gap = 0;
	int   errors = 0;
	int   n_ins = 0, n_qry = 0, n_drop = 0, n_empty = 0;

	hull_cmd_t pending_cmds[$];
	hull_res_t expected_res[$];
	hull_cmd_t cur;

	// envelope predictor state
	longint env_k[TBL_DEPTH];
	longint env_m[TBL_DEPTH];
	longint env_bp[TBL_DEPTH];
	int     env_cnt = 0;

	mlh_cmd_if cmd();
	mlh_res_if res();

	max_line_hull_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.res    (res.source)
	);

	always #6 clk = ~clk;

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if (((a < 0) != (b < 0)) && (a % b) != 0)
			q -= 1;
		return q;
	endfunction

	function automatic bit set_break(int a, int b);
		if (b >= env_cnt) begin
			env_bp[a] = mlh_pkg::LIM_POS;
			return 1'b0;
		end
		if (env_k[a] == env_k[b])
			env_bp[a] = (env_m[a] > env_m[b]) ? mlh_pkg::LIM_POS : mlh_pkg::LIM_NEG;
		else
			env_bp[a] = floor_quot(env_m[b] - env_m[a], env_k[a] - env_k[b]);
		return env_bp[a] >= env_bp[b];
	endfunction

	function automatic void drop_line(int i);
		for (int j = i; j + 1 < env_cnt; j++) begin
			env_k[j]  = env_k[j+1];
			env_m[j]  = env_m[j+1];
			env_bp[j] = env_bp[j+1];
		end
		env_cnt--;
	endfunction

	function automatic void add_line(longint k, longint m);
		int pos, x, y;
		bit d;
		pos = 0;
		while (pos < env_cnt && env_k[pos] <= k)
			pos++;
		for (int j = env_cnt; j > pos; j--) begin
			env_k[j]  = env_k[j-1];
			env_m[j]  = env_m[j-1];
			env_bp[j] = env_bp[j-1];
		end
		env_k[pos] = k;
		env_m[pos] = m;
		env_bp[pos] = 0;
		env_cnt++;
		y = pos;
		x = pos;
		while (set_break(y, y + 1))
			drop_line(y + 1);
		if (x != 0) begin
			x--;
			if (set_break(x, y)) begin
				drop_line(y);
				d = set_break(x, x + 1);
			end
		end
		forever begin
			y = x;
			if (y == 0)
				break;
			x = y - 1;
			if (env_bp[x] >= env_bp[y]) begin
				drop_line(y);
				d = set_break(x, x + 1);
			end else begin
				break;
			end
		end
	endfunction

	function automatic hull_res_t envelope_step(hull_cmd_t c);
		hull_res_t r;
		int i;
		r = '{0, 1'b0, 1'b0};
		if (c.func == FN_INSERT) begin
			n_ins++;
			if (env_cnt >= TBL_DEPTH) begin
				r.dropped = 1'b1;
				n_drop++;
			end else begin
				add_line(c.slope, c.intercept);
			end
		end else begin
			n_qry++;
			if (env_cnt == 0) begin
				r.empty_res = 1'b1;
				n_empty++;
			end else begin
				i = 0;
				while (i + 1 < env_cnt && env_bp[i] < c.qx)
					i++;
				r.value = env_k[i] * c.qx + env_m[i];
			end
		end
		return r;
	endfunction

	task automatic enqueue_cmd(hull_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic push_insert(longint k, longint m);
		hull_cmd_t c;
		c = '{FN_INSERT, k, m, longint'($urandom) <<< 32 >>> 32};
		enqueue_cmd(c);
	endtask

	task automatic push_query(longint x);
		hull_cmd_t c;
		c = '{FN_QUERY, longint'(int'($urandom)),
			longint'($signed({$urandom, $urandom}) <<< 1) >>> 1, x};
		enqueue_cmd(c);
	endtask

	function automatic longint rand_slope();
		if ($urandom_range(0, 2) == 0)
			return longint'(int'($urandom));
		return longint'($urandom_range(0, 2000)) - 1000;
	endfunction

	function automatic longint rand_icpt();
		longint v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return (v <<< 1) >>> 1;
			1: return (v <<< 23) >>> 23;
			default: return longint'($urandom_range(0, 200000)) - 100000;
		endcase
	endfunction

	function automatic longint rand_x();
		case ($urandom_range(0, 3))
			0: return longint'(int'($urandom));
			1: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
			default: return longint'($urandom_range(0, 4000)) - 2000;
		endcase
	endfunction

	// transfer on the command channel: predict, then advance the driver
	always @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			expected_res.insert(expected_res.size(), envelope_step(cur));
			cmd_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!started) begin
			cmd.valid <= 1'b0;
			cmd.func <= 1'b0;
			cmd.slope <= '0;
			cmd.intercept <= '0;
			cmd.query_point <= '0;
		end else if (!cmd.valid || cmd_taken) begin
			cmd_taken = 1'b0;
			if (cmd_gap > 0) begin
				cmd_gap--;
				cmd.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cur = pending_cmds.pop_front();
				cmd.valid <= 1'b1;
				cmd.func <= cur.func;
				cmd.slope <= cur.slope[31:0];
				cmd.intercept <= cur.intercept[62:0];
				cmd.query_point <= cur.qx[31:0];
				cmd_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		hull_res_t e;
		if (res.valid && res.ready) begin
			res_taken = 1'b1;
			if (expected_res.size() == 0) begin
				$error("unexpected result value=%0d", res.value);
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (res.value !== e.value) begin
					$error("value: expected %0d, got %0d", e.value, res.value);
					errors++;
				end
				if (res.empty_res !== e.empty_res) begin
					$error("empty_res: expected %0d, got %0d", e.empty_res, res.empty_res);
					errors++;
				end
				if (res.dropped !== e.dropped) begin
					$error("dropped: expected %0d, got %0d", e.dropped, res.dropped);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (res_taken) begin
			res_taken = 1'b0;
			res_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		end
		if (res_gap > 0 && res.ready !== 1'b1)
			res_gap--;
		res.ready <= started && !hold && res_gap == 0;
	end

	// long receiver hold-off while commands keep coming
	initial begin
		wait (n_ins + n_qry > 60);
		@(negedge clk);
		hold = 1'b1;
		repeat (400) @(posedge clk);
		hold = 1'b0;
	end

	initial begin
		#50ms;
		$display("[max_line_hull_table] ERROR");
		$finish;
	end

	initial begin
		int tries;
		longint s;
		res.ready = 1'b0;
		cmd.valid = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		started = 1'b1;

		// directed
		push_query(0);
		push_insert(0, 0);
		push_query(64'sd2147483647);
		push_query(-64'sd2147483648);
		push_insert(64'sd2147483647, 64'sd4611686018427387903);
		push_insert(-64'sd2147483648, -64'sd4611686018427387904);
		push_query(64'sd2147483647);
		push_query(-64'sd2147483648);
		push_insert(5, 100);
		push_insert(5, 50);
		push_insert(5, 200);
		push_insert(-64'sd2147483648, 64'sd4611686018427387903);
		push_query(0);
		push_query(-1);
		push_query(1);
		push_insert(3, -64'sd4611686018427387904);
		push_query(-64'sd2147483648);
		push_query(12345);

		// random: runs of inserts and queries
		while (n_ins + n_qry + pending_cmds.size() < 260) begin
			repeat ($urandom_range(1, 6)) push_insert(rand_slope(), rand_icpt());
			repeat ($urandom_range(1, 8)) push_query(rand_x());
			wait (pending_cmds.size() < 4);
		end

		// fill the table with lines tangent to a parabola, then overflow it
		wait (pending_cmds.size() == 0 && expected_res.size() == 0);
		tries = 0;
		while (env_cnt < TBL_DEPTH && tries < 128) begin
			s = -64'sd2147483648 + longint'(tries % 64) * (64'sd1 <<< 26);
			push_insert(s, (64'sd1 <<< 61) + tries / 64 - ((s * s) >>> 2));
			if (tries % 3 == 0)
				push_query(rand_x());
			tries++;
			wait (pending_cmds.size() == 0 && expected_res.size() == 0);
		end
		repeat (6) push_insert(rand_slope(), rand_icpt());
		repeat (40) push_query(rand_x());

		wait (pending_cmds.size() == 0 && !cmd.valid && expected_res.size() == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d inserts (%0d dropped on a full table), %0d queries (%0d empty)",
			n_ins, n_drop, n_qry, n_empty);
		if (errors == 0 && expected_res.size() == 0)
			$display("[max_line_hull_table] OK");
		else
			$display("[max_line_hull_table] ERROR");
		$finish;
	end

endmodule

// File: max_line_hull_table.f
hw/rtl/mlh_pkg.sv
hw/rtl/mlh_if.sv
hw/rtl/mlh_floor_div.sv
hw/rtl/max_line_hull_table.sv
tb/testbench.sv
